// File: src/rfr_pkg.sv
// Shared constants, types and a helper function of the remote frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

  // Frame layout.
  localparam int FRAME_LEN_DEF = 9;
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'hBB;
  localparam int POS_BUTTONS  = 2;
  localparam int POS_THROTTLE = 4;
  localparam int POS_STEER    = 5;
  localparam int POS_PACKET   = 7;

  // Button bit positions inside the button byte.
  localparam int BTN1_BIT = 0;
  localparam int BTN2_BIT = 1;
  localparam int BTN3_BIT = 2;
  localparam int BTN4_BIT = 3;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_LOW  = 1'd1;
  localparam logic [7:0] DZ_HIGH_RESET = 8'd152;
  localparam logic [7:0] DZ_LOW_RESET  = 8'd102;

  // Direction codes for throttle and steering.
  localparam logic [1:0] DIR_NEUTRAL  = 2'd0;
  localparam logic [1:0] DIR_POSITIVE = 2'd1;
  localparam logic [1:0] DIR_NEGATIVE = 2'd2;

  // One completed frame as handed from the parser to the result stage.
  typedef struct packed {
    logic       done;
    logic       ok;
    logic [7:0] buttons;
    logic [7:0] throttle;
    logic [7:0] steer;
    logic [7:0] packet;
  } frame_t;

  // Classes a raw stick value; the upper threshold takes priority.
  function automatic logic [1:0] classify(input logic [7:0] v, input logic [7:0] hi,
                                          input logic [7:0] lo);
    logic [1:0] dir;
    if (v > hi) begin
      dir = DIR_POSITIVE;
    end else if (v < lo) begin
      dir = DIR_NEGATIVE;
    end else begin
      dir = DIR_NEUTRAL;
    end
    return dir;
  endfunction

endpackage

`default_nettype wire

// File: src/rfr_parser.sv
// Byte-level frame parser: sync search, running checksum and field capture.
`timescale 1ns / 1ps
`default_nettype none

module rfr_parser import rfr_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  output logic            last_pending,
  output frame_t          frame
);

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  logic [1:0]       phase;
  logic [IDX_W-1:0] idx;
  logic [7:0]       sum;
  logic [7:0]       held_buttons;
  logic [7:0]       held_throttle;
  logic [7:0]       held_steer;
  logic [7:0]       held_packet;

  assign last_pending = (phase == PH_COLLECT) && (idx == LAST_IDX);

  always_comb begin
    frame.done     = fire && last_pending;
    frame.ok       = (rx_byte == sum);
    frame.buttons  = held_buttons;
    frame.throttle = held_throttle;
    frame.steer    = held_steer;
    frame.packet   = held_packet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      idx   <= '0;
      sum   <= '0;
    end else if (fire) begin
      case (phase)
        PH_SECOND: begin
          // Anything but the second sync byte is dropped without leaving the phase.
          if (rx_byte == SYNC_SECOND) begin
            phase <= PH_COLLECT;
            idx   <= IDX_W'(2);
            sum   <= sum + rx_byte;
          end
        end
        PH_COLLECT: begin
          if (idx != LAST_IDX) begin
            sum <= sum + rx_byte;
            idx <= idx + 1'b1;
          end else begin
            phase <= PH_HUNT;
            idx   <= '0;
            sum   <= '0;
          end
        end
        default: begin
          if (rx_byte == SYNC_FIRST) begin
            phase <= PH_SECOND;
            idx   <= IDX_W'(1);
            sum   <= rx_byte;
          end else begin
            phase <= PH_HUNT;
          end
        end
      endcase
    end
  end

  // Captured payload bytes; always written before the checksum byte reads them.
  always_ff @(posedge clk) begin
    if (fire && (phase == PH_COLLECT)) begin
      if (idx == IDX_W'(POS_BUTTONS))  held_buttons  <= rx_byte;
      if (idx == IDX_W'(POS_THROTTLE)) held_throttle <= rx_byte;
      if (idx == IDX_W'(POS_STEER))    held_steer    <= rx_byte;
      if (idx == IDX_W'(POS_PACKET))   held_packet   <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: src/rfr_result.sv
// Frame decode, button history, failure counter and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rfr_result import rfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire frame_t      frame,
  input  wire logic [7:0]  dz_high,
  input  wire logic [7:0]  dz_low,
  input  wire logic        res_ready,
  output logic             res_valid,
  output logic             frame_ok,
  output logic [1:0]       throttle_dir,
  output logic [1:0]       steer_dir,
  output logic [7:0]       throttle_raw,
  output logic [7:0]       steer_raw,
  output logic [7:0]       packet_id,
  output logic             button1_changed,
  output logic             button2_changed,
  output logic             button3_changed,
  output logic             button4_level,
  output logic [15:0]      error_count
);

  logic [2:0]  last_buttons;
  logic [15:0] fail_count;
  logic [15:0] fail_count_next;
  logic [2:0]  now3;
  logic [2:0]  diff;

  assign now3            = frame.buttons[BTN3_BIT:BTN1_BIT];
  assign diff            = now3 ^ last_buttons;
  assign fail_count_next = fail_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      last_buttons <= '0;
      fail_count   <= '0;
    end else if (frame.done) begin
      res_valid <= 1'b1;
      if (frame.ok) begin
        last_buttons <= now3;
      end else begin
        fail_count <= fail_count_next;
      end
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      frame_ok <= frame.ok;
      if (frame.ok) begin
        throttle_dir    <= classify(frame.throttle, dz_high, dz_low);
        steer_dir       <= classify(frame.steer, dz_high, dz_low);
        throttle_raw    <= frame.throttle;
        steer_raw       <= frame.steer;
        packet_id       <= frame.packet;
        button1_changed <= diff[BTN1_BIT];
        button2_changed <= diff[BTN2_BIT];
        button3_changed <= diff[BTN3_BIT];
        button4_level   <= frame.buttons[BTN4_BIT];
        error_count     <= fail_count;
      end else begin
        throttle_dir    <= DIR_NEUTRAL;
        steer_dir       <= DIR_NEUTRAL;
        throttle_raw    <= '0;
        steer_raw       <= '0;
        packet_id       <= '0;
        button1_changed <= 1'b0;
        button2_changed <= 1'b0;
        button3_changed <= 1'b0;
        button4_level   <= 1'b0;
        error_count     <= fail_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/remote_frame_receiver_unit.sv
// Top level of the remote-control frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// The block takes received serial bytes on the rx channel (rx_valid, rx_ready,
// rx_byte), one beat per byte, and looks for fixed-length frames that open with
// 0xAA then 0xBB and close with an additive checksum byte. Every completed frame
// gives exactly one beat on the result channel (res_valid, res_ready and the
// decoded fields); sync and payload bytes give none.
// Bytes are taken at one byte per cycle unless a checksum byte is held off (below).
// The result beat appears in the cycle after the checksum byte is accepted, from
// the result register fed by the parser's running sum and captures.
// The result register sits between the two channels, so payload bytes keep
// flowing while a finished result waits. Only the checksum byte of the next
// frame is held off (rx_ready low) while an earlier result is still not taken.
// Deadzone thresholds are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while the block is idle, which the block does not enforce. A write takes
// effect on the next clock edge. Synchronous reset returns the parser to sync search,
// clears the button history and the failure count, empties the result register and
// restores the default thresholds. There is no clearing pass; the block is ready right after.
module remote_frame_receiver_unit import rfr_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rx_valid,
  output logic                       rx_ready,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic                       frame_ok,
  output logic [1:0]                 throttle_dir,
  output logic [1:0]                 steer_dir,
  output logic [7:0]                 throttle_raw,
  output logic [7:0]                 steer_raw,
  output logic [7:0]                 packet_id,
  output logic                       button1_changed,
  output logic                       button2_changed,
  output logic                       button3_changed,
  output logic                       button4_level,
  output logic [15:0]                error_count
);

  logic   [7:0] dz_high;
  logic   [7:0] dz_low;
  logic         rx_fire;
  logic         last_pending;
  frame_t       frame;

  // Only a checksum byte can produce a result, so only it waits on the output.
  assign rx_ready = !last_pending || !res_valid || res_ready;
  assign rx_fire  = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_high <= DZ_HIGH_RESET;
      dz_low  <= DZ_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DZ_HIGH: dz_high <= cfg_data;
        REG_DZ_LOW:  dz_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfr_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (rx_fire),
    .rx_byte     (rx_byte),
    .last_pending(last_pending),
    .frame       (frame)
  );

  rfr_result u_result (
    .clk            (clk),
    .rst            (rst),
    .frame          (frame),
    .dz_high        (dz_high),
    .dz_low         (dz_low),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .frame_ok       (frame_ok),
    .throttle_dir   (throttle_dir),
    .steer_dir      (steer_dir),
    .throttle_raw   (throttle_raw),
    .steer_raw      (steer_raw),
    .packet_id      (packet_id),
    .button1_changed(button1_changed),
    .button2_changed(button2_changed),
    .button3_changed(button3_changed),
    .button4_level  (button4_level),
    .error_count    (error_count)
  );

endmodule

`default_nettype wire

// File: src/rfr_checker.sv
// Port-level checks of the frame receiver and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic        frame_ok,
  input wire logic [1:0]  throttle_dir,
  input wire logic [1:0]  steer_dir,
  input wire logic [7:0]  packet_id,
  input wire logic [15:0] error_count
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Input is only held off while a result is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (res_valid && !res_ready))
    else $error("rx stalled without a pending result");

  // A stalled result beat keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(frame_ok) && $stable(packet_id)
                                   && $stable(error_count)))
    else $error("result changed while stalled");

  // A failed frame carries no decoded directions and a zero packet id.
  a_bad_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !frame_ok) |-> (throttle_dir == 2'd0 && steer_dir == 2'd0
                                  && packet_id == 8'd0))
    else $error("failed frame carries decoded fields");

  // Direction codes never take the unused value.
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (throttle_dir != 2'd3 && steer_dir != 2'd3))
    else $error("unused direction code");

endmodule

bind remote_frame_receiver_unit rfr_checker u_rfr_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .frame_ok    (frame_ok),
  .throttle_dir(throttle_dir),
  .steer_dir   (steer_dir),
  .packet_id   (packet_id),
  .error_count (error_count)
);

`default_nettype wire

// File: dv/frame_result_checker.sv
// Checker that predicts and compares the decoded frames of the remote frame receiver.
`timescale 1ns / 1ps

module frame_result_checker import rfr_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  input  logic                  rx_ready,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  logic                  frame_ok,
  input  logic [1:0]            throttle_dir,
  input  logic [1:0]            steer_dir,
  input  logic [7:0]            throttle_raw,
  input  logic [7:0]            steer_raw,
  input  logic [7:0]            packet_id,
  input  logic                  button1_changed,
  input  logic                  button2_changed,
  input  logic                  button3_changed,
  input  logic                  button4_level,
  input  logic [15:0]           error_count,
  output int unsigned           mismatches,
  output int unsigned           frames_pending,
  output int unsigned           good_frames,
  output int unsigned           bad_frames
);

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic        ok;
    logic [1:0]  throttle_dir;
    logic [1:0]  steer_dir;
    logic [7:0]  throttle;
    logic [7:0]  steer;
    logic [7:0]  packet;
    logic        btn1_changed;
    logic        btn2_changed;
    logic        btn3_changed;
    logic        btn4_level;
    logic [15:0] errors;
  } frame_result_t;

  frame_result_t expected_frames[$];

  parse_phase_e phase;
  logic [3:0]   byte_pos;
  logic [7:0]   running_sum;
  logic [7:0]   held_buttons;
  logic [7:0]   held_throttle;
  logic [7:0]   held_steer;
  logic [7:0]   held_packet;
  logic [2:0]   prev_buttons;
  logic [15:0]  fail_total;
  logic [7:0]   dz_high;
  logic [7:0]   dz_low;

  // The upper threshold is tested first, so it wins when the thresholds cross.
  function automatic logic [1:0] stick_direction(input logic [7:0] v);
    if (v > dz_high) begin
      return DIR_POSITIVE;
    end else if (v < dz_low) begin
      return DIR_NEGATIVE;
    end
    return DIR_NEUTRAL;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic predict_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [2:0]    diff;
    case (phase)
      HUNT_SECOND: begin
        if (b == SYNC_SECOND) begin
          phase = COLLECT;
          byte_pos = 4'd2;
          running_sum = running_sum + b;
        end
      end
      COLLECT: begin
        if (byte_pos < 4'(FRAME_LEN - 1)) begin
          case (int'(byte_pos))
            POS_BUTTONS:  held_buttons  = b;
            POS_THROTTLE: held_throttle = b;
            POS_STEER:    held_steer    = b;
            POS_PACKET:   held_packet   = b;
            default: ;
          endcase
          running_sum = running_sum + b;
          byte_pos = byte_pos + 4'd1;
        end else begin
          r = '0;
          if (b == running_sum) begin
            diff = held_buttons[2:0] ^ prev_buttons;
            r.ok           = 1'b1;
            r.throttle_dir = stick_direction(held_throttle);
            r.steer_dir    = stick_direction(held_steer);
            r.throttle     = held_throttle;
            r.steer        = held_steer;
            r.packet       = held_packet;
            r.btn1_changed = diff[BTN1_BIT];
            r.btn2_changed = diff[BTN2_BIT];
            r.btn3_changed = diff[BTN3_BIT];
            r.btn4_level   = held_buttons[BTN4_BIT];
            r.errors       = fail_total;
            prev_buttons = held_buttons[2:0];
            good_frames++;
          end else begin
            fail_total = fail_total + 16'd1;
            r.errors = fail_total;
            bad_frames++;
          end
          expected_frames.push_back(r);
          phase = HUNT_FIRST;
          byte_pos = 4'd0;
          running_sum = 8'd0;
        end
      end
      default: begin
        if (b == SYNC_FIRST) begin
          phase = HUNT_SECOND;
          byte_pos = 4'd1;
          running_sum = b;
        end else begin
          phase = HUNT_FIRST;
        end
      end
    endcase
  endtask

  initial begin
    mismatches = 0;
    frames_pending = 0;
    good_frames = 0;
    bad_frames = 0;
  end

  always @(posedge clk) begin
    frame_result_t e;
    if (rst) begin
      phase = HUNT_FIRST;
      byte_pos = 4'd0;
      running_sum = 8'd0;
      held_buttons = 8'd0;
      held_throttle = 8'd0;
      held_steer = 8'd0;
      held_packet = 8'd0;
      prev_buttons = 3'd0;
      fail_total = 16'd0;
      dz_high = DZ_HIGH_RESET;
      dz_low = DZ_LOW_RESET;
      expected_frames.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result beat arrived with no frame outstanding");
          mismatches++;
        end else begin
          e = expected_frames.pop_front();
          check_field("frame_ok", 16'(e.ok), 16'(frame_ok));
          check_field("throttle_dir", 16'(e.throttle_dir), 16'(throttle_dir));
          check_field("steer_dir", 16'(e.steer_dir), 16'(steer_dir));
          check_field("throttle_raw", 16'(e.throttle), 16'(throttle_raw));
          check_field("steer_raw", 16'(e.steer), 16'(steer_raw));
          check_field("packet_id", 16'(e.packet), 16'(packet_id));
          check_field("button1_changed", 16'(e.btn1_changed), 16'(button1_changed));
          check_field("button2_changed", 16'(e.btn2_changed), 16'(button2_changed));
          check_field("button3_changed", 16'(e.btn3_changed), 16'(button3_changed));
          check_field("button4_level", 16'(e.btn4_level), 16'(button4_level));
          check_field("error_count", e.errors, error_count);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_DZ_HIGH) begin
          dz_high = cfg_data[7:0];
        end else if (cfg_index == REG_DZ_LOW) begin
          dz_low = cfg_data[7:0];
        end
      end
      if (rx_valid && rx_ready) begin
        predict_rx_byte(rx_byte);
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

// File: dv/tb.sv
// Top of the remote frame receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The testbench feeds serial bytes into the receiver and lets the checker module
// predict every decoded frame and compare it with the result beats. Stimulus runs
// in phases: a short directed opening, then random traffic under four idle
// patterns and several threshold settings, then a pressure phase in which the
// result side holds off long enough that the block has to stall its byte input.
module tb;
  import rfr_pkg::*;

  localparam int          HOLDOFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  logic                  clk;
  logic                  rst;
  logic                  rx_valid;
  logic                  rx_ready;
  logic [7:0]            rx_byte;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  res_valid;
  logic                  res_ready;
  logic                  frame_ok;
  logic [1:0]            throttle_dir;
  logic [1:0]            steer_dir;
  logic [7:0]            throttle_raw;
  logic [7:0]            steer_raw;
  logic [7:0]            packet_id;
  logic                  button1_changed;
  logic                  button2_changed;
  logic                  button3_changed;
  logic                  button4_level;
  logic [15:0]           error_count;

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned good_frames;
  int unsigned bad_frames;

  // Stimulus-side knobs. The thresholds are tracked here only to aim stick
  // values at the deadzone edges; the checker keeps its own copy.
  int unsigned bytes_sent;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic        holdoff_req;
  logic [7:0]  dz_high;
  logic [7:0]  dz_low;
  int unsigned cycle_count;

  remote_frame_receiver_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .rx_valid        (rx_valid),
    .rx_ready        (rx_ready),
    .rx_byte         (rx_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .frame_ok        (frame_ok),
    .throttle_dir    (throttle_dir),
    .steer_dir       (steer_dir),
    .throttle_raw    (throttle_raw),
    .steer_raw       (steer_raw),
    .packet_id       (packet_id),
    .button1_changed (button1_changed),
    .button2_changed (button2_changed),
    .button3_changed (button3_changed),
    .button4_level   (button4_level),
    .error_count     (error_count)
  );

  frame_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .rx_valid        (rx_valid),
    .rx_ready        (rx_ready),
    .rx_byte         (rx_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .frame_ok        (frame_ok),
    .throttle_dir    (throttle_dir),
    .steer_dir       (steer_dir),
    .throttle_raw    (throttle_raw),
    .steer_raw       (steer_raw),
    .packet_id       (packet_id),
    .button1_changed (button1_changed),
    .button2_changed (button2_changed),
    .button3_changed (button3_changed),
    .button4_level   (button4_level),
    .error_count     (error_count),
    .mismatches      (mismatches),
    .frames_pending  (frames_pending),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls at the current rate, plus one long hold-off
  // counted here when the stimulus asks for it. During the hold-off the first
  // finished result sits in the output register, so the checksum byte of the
  // following frame cannot be taken and rx_ready drops.
  initial begin : result_sink
    bit holdoff_seen;
    holdoff_seen = 1'b0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req && !holdoff_seen) begin
        holdoff_seen = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else begin
        res_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Offers one byte and returns at the falling edge after its beat. Called at a
  // falling edge; any idle cycles go in front of the byte, so valid is never
  // dropped and raised again within one time step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!(rx_valid && rx_ready));
    bytes_sent++;
    @(negedge clk);
  endtask

  // A whole frame: both sync bytes, payload with the given fields and random
  // filler, and the additive checksum, optionally spoiled.
  task automatic send_frame(input bit corrupt, input logic [7:0] buttons,
                            input logic [7:0] throttle, input logic [7:0] steer,
                            input logic [7:0] packet);
    logic [7:0] frm [FRAME_LEN_DEF];
    logic [7:0] sum;
    frm[0] = SYNC_FIRST;
    frm[1] = SYNC_SECOND;
    for (int i = 2; i < FRAME_LEN_DEF - 1; i++) begin
      frm[i] = 8'($urandom);
    end
    frm[POS_BUTTONS]  = buttons;
    frm[POS_THROTTLE] = throttle;
    frm[POS_STEER]    = steer;
    frm[POS_PACKET]   = packet;
    sum = 8'd0;
    for (int i = 0; i < FRAME_LEN_DEF - 1; i++) begin
      sum = sum + frm[i];
    end
    // XOR with a nonzero value guarantees the checksum really is wrong.
    frm[FRAME_LEN_DEF - 1] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < FRAME_LEN_DEF; i++) begin
      send_byte(frm[i]);
    end
  endtask

  // Stick values cluster around both thresholds and the ends of the range so
  // that every comparison boundary is hit often, not just by chance.
  function automatic logic [7:0] pick_stick();
    case ($urandom_range(5))
      0: return dz_high + 8'($urandom_range(2)) - 8'd1;
      1: return dz_low + 8'($urandom_range(2)) - 8'd1;
      2: return 8'd0;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames with random content; some line noise between
  // frames, some openings that break after the first sync byte, and about one
  // frame in seven with a bad checksum.
  task automatic random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  junk;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (pick < 14) begin
        // A first sync byte followed by anything but the second one; the block
        // keeps waiting for the second sync byte and drops the junk.
        send_byte(SYNC_FIRST);
        do begin
          junk = 8'($urandom);
        end while (junk == SYNC_SECOND);
        send_byte(junk);
      end
      send_frame($urandom_range(99) < 15, 8'($urandom), pick_stick(), pick_stick(),
                 8'($urandom));
    end
  endtask

  // Configuration writes happen only while the block has nothing in flight.
  // The write strobe is dropped again before the task returns.
  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_DZ_HIGH) begin
      dz_high = value;
    end else begin
      dz_low = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted frame has been delivered, then lets the block
  // settle: a trailing sync or payload byte makes no result but may still be in
  // the parser, and each result passes through the result register.
  task automatic wait_idle();
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'd0;
    cfg_we = 1'b0;
    cfg_index = REG_DZ_HIGH;
    cfg_data = '0;
    holdoff_req = 1'b0;
    bytes_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    dz_high = DZ_HIGH_RESET;
    dz_low = DZ_LOW_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening at the reset thresholds. A stray second sync byte is
    // dropped while hunting for the first; a repeated first sync byte and a
    // junk byte are dropped while waiting for the second.
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(8'h5C);
    // Rest of a good frame: all four buttons set, throttle at full scale,
    // steering at zero, packet id at full scale. The checksum over
    // AA BB 0F 00 FF 00 55 FF wraps to C7.
    send_byte(SYNC_SECOND);
    send_byte(8'h0F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'hC7);
    // A bad checksum with the opposite extremes: result fields must read zero
    // and the button history must stay untouched.
    send_frame(1'b1, 8'hF0, 8'h00, 8'hFF, 8'h00);
    // Sticks exactly on the thresholds are neutral; buttons go back to zero.
    send_frame(1'b0, 8'h00, DZ_HIGH_RESET, DZ_LOW_RESET, 8'h80);
    rx_valid <= 1'b0;

    // Random phases, each with its own thresholds and idle pattern.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          // Widest deadzone: no value is ever above 255 or below 0.
          write_threshold(REG_DZ_HIGH, 8'd255);
          write_threshold(REG_DZ_LOW, 8'd0);
          sender_idle_pct = 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          // Crossed thresholds: the upper test wins for anything above zero.
          write_threshold(REG_DZ_HIGH, 8'd0);
          write_threshold(REG_DZ_LOW, 8'd255);
          sender_idle_pct = 78;
          receiver_stall_pct <= 0;
        end
        2: begin
          // Zero-width deadzone.
          write_threshold(REG_DZ_HIGH, 8'd128);
          write_threshold(REG_DZ_LOW, 8'd128);
          sender_idle_pct = 0;
          receiver_stall_pct <= 78;
        end
        default: begin
          write_threshold(REG_DZ_HIGH, 8'($urandom));
          write_threshold(REG_DZ_LOW, 8'($urandom));
          sender_idle_pct = 38;
          receiver_stall_pct <= 38;
        end
      endcase
      random_traffic(160);
      rx_valid <= 1'b0;
    end

    // Pressure phase at the default thresholds: the sender streams back to
    // back while the result side holds off, so the block fills and stalls.
    wait_idle();
    write_threshold(REG_DZ_HIGH, DZ_HIGH_RESET);
    write_threshold(REG_DZ_LOW, DZ_LOW_RESET);
    sender_idle_pct = 0;
    receiver_stall_pct <= 10;
    holdoff_req <= 1'b1;
    repeat (4) begin
      send_frame($urandom_range(99) < 15, 8'($urandom), pick_stick(), pick_stick(),
                 8'($urandom));
    end
    holdoff_req <= 1'b0;
    rx_valid <= 1'b0;

    wait_idle();
    repeat (8) @(negedge clk);

    $display("Run covered %0d bytes in %0d cycles: %0d good and %0d bad frames decoded.",
             bytes_sent, cycle_count, good_frames, bad_frames);
    $display("Thresholds swept over reset, widest, crossed, zero-width and random values.");
    if (mismatches == 0 && frames_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
